[src/lbp_pkg.sv]
// Shared types and constants for the LSB-first bit packer.
package lbp_pkg;

  localparam int OP_W   = 2;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 6;
  localparam int BYTE_W = 8;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd1;
  localparam logic [OP_W-1:0] OP_ALIGN = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] op;
    logic            shift;
  } lbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_byte;
    logic last;
  } lbp_sts_t;

endpackage : lbp_pkg

[src/lbp_if.sv]
// Valid/ready channel interfaces for the packer's input items and output words.
interface lbp_in_if;
  import lbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [DATA_W-1:0] bit_data;
  logic [CNT_W-1:0]  bit_count;
  logic              pad_ones;

  modport source (output valid, opcode, bit_data, bit_count, pad_ones, input ready);
  modport sink   (input valid, opcode, bit_data, bit_count, pad_ones, output ready);
endinterface : lbp_in_if

interface lbp_out_if;
  import lbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface : lbp_out_if

[src/lsb_first_bit_packer_core.sv]
// Top level of the LSB-first bit packer: controller and datapath.
//
// Usage: input items arrive on in_ch (valid/ready). Opcode put appends the low
// bit_count bits of bit_data (saturated to MAX_FIELD_BITS, bits above 32 taken
// as zeros) above the held partial byte; flush pads a non-empty partial byte
// with ones or zeros (pad_ones) to a full byte; align drops the partial bits.
// Opcode three is ignored. Each completed byte leaves on out_ch as one word,
// with last_of_run set on the final word caused by the item.
// Sequencing: an item is taken while the controller is idle; its first word is
// offered in the cycle after, and further words follow one per cycle while
// out_ch.ready is high. A new item is accepted only once every word that the
// item causes has been taken (up to four for a 32-bit put), as the single
// accumulator register shifts out one byte per word taken.
// Reset (rst_n low, synchronous) empties the partial byte and returns the
// controller to idle. When the receiver stalls, the offered word is held
// unchanged and no new item is accepted until the item's last word is taken.
module lsb_first_bit_packer_core #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  lbp_in_if.sink    in_ch,
  lbp_out_if.source out_ch
);
  import lbp_pkg::*;

  lbp_cmd_t cmd;
  lbp_sts_t sts;

  // Controller: owns both handshakes and issues load/shift commands.
  lbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .in_op     (in_ch.opcode),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: the accumulator holds the partial byte between items and the
  // pending bytes of the current item, lowest byte offered first.
  lbp_dp #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .bit_data    (in_ch.bit_data),
    .bit_count   (in_ch.bit_count),
    .pad_ones    (in_ch.pad_ones),
    .sts         (sts),
    .out_byte    (out_ch.out_byte),
    .last_of_run (out_ch.last_of_run)
  );

endmodule : lsb_first_bit_packer_core

[src/lbp_ctrl.sv]
// Controller state machine: input acceptance and output word sequencing.
module lbp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        in_op,
  output lbp_pkg::lbp_cmd_t cmd,
  input  lbp_pkg::lbp_sts_t sts
);
  import lbp_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state_r;
  logic state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT) && sts.has_byte;

  always_comb begin
    cmd.load  = in_valid && in_ready;
    cmd.op    = in_op;
    cmd.shift = out_valid && out_ready;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.has_byte || (cmd.shift && sts.last)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !sts.has_byte)
    else $error("controller idle while a full word is still held");
  a_load_enters_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_EMIT))
    else $error("accepted item did not start emission");
  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift && sts.last) |=> (state_r == S_IDLE))
    else $error("controller stayed busy after the final word");

endmodule : lbp_ctrl

[src/lbp_dp.sv]
// Datapath: bit accumulator, field masking and alignment, byte extraction.
module lbp_dp #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lbp_pkg::lbp_cmd_t          cmd,
  input  logic [lbp_pkg::DATA_W-1:0] bit_data,
  input  logic [lbp_pkg::CNT_W-1:0]  bit_count,
  input  logic                       pad_ones,
  output lbp_pkg::lbp_sts_t          sts,
  output logic [lbp_pkg::BYTE_W-1:0] out_byte,
  output logic                       last_of_run
);
  import lbp_pkg::*;

  localparam int ACC_W  = MAX_FIELD_BITS + BYTE_W;
  localparam int TOT_W  = $clog2(ACC_W + 1);
  localparam int MAXC_W = $clog2(MAX_FIELD_BITS + 1);
  localparam int SAT_W  = (MAXC_W > CNT_W) ? MAXC_W : CNT_W;

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [2:0]        held;
  logic [SAT_W-1:0]  cnt_ext, cnt_sat;
  logic [DATA_W-1:0] masked;
  logic [ACC_W-1:0]  placed;
  logic [BYTE_W-1:0] pad;

  assign held    = total_r[2:0];
  assign cnt_ext = SAT_W'(bit_count);
  assign cnt_sat = (cnt_ext > SAT_W'(MAX_FIELD_BITS)) ? SAT_W'(MAX_FIELD_BITS) : cnt_ext;

  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      masked[i] = bit_data[i] & (SAT_W'(i) < cnt_sat);
    end
  end

  assign placed = ACC_W'(masked) << held;
  assign pad    = pad_ones ? (BYTE_W'(8'hff) << held) : '0;

  assign sts.has_byte = (total_r >= TOT_W'(BYTE_W));
  assign sts.last     = (total_r < TOT_W'(2 * BYTE_W));
  assign out_byte     = acc_r[BYTE_W-1:0];
  assign last_of_run  = sts.last;

  always_comb begin
    acc_nxt   = acc_r;
    total_nxt = total_r;
    if (cmd.load) begin
      case (cmd.op)
        OP_PUT: begin
          acc_nxt   = acc_r | placed;
          total_nxt = TOT_W'(held) + TOT_W'(cnt_sat);
        end
        OP_FLUSH: begin
          if (held != 3'd0) begin
            acc_nxt   = acc_r | ACC_W'(pad);
            total_nxt = TOT_W'(BYTE_W);
          end
        end
        OP_ALIGN: begin
          acc_nxt   = '0;
          total_nxt = '0;
        end
        default: ;
      endcase
    end else if (cmd.shift) begin
      acc_nxt   = acc_r >> BYTE_W;
      total_nxt = total_r - TOT_W'(BYTE_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      total_r <= '0;
    end else begin
      acc_r   <= acc_nxt;
      total_r <= total_nxt;
    end
  end

  a_shift_drops_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift && !cmd.load) |=> (total_r == $past(total_r) - TOT_W'(BYTE_W)))
    else $error("bit count did not drop by one word after a transfer");
  a_align_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && cmd.op == OP_ALIGN) |=> (total_r == '0 && acc_r == '0))
    else $error("align left bits behind");
  a_clean_partial: assert property (@(posedge clk) disable iff (!rst_n)
    !sts.has_byte |-> ((acc_r >> total_r) == '0))
    else $error("bits set above the held count");

endmodule : lbp_dp
